### hdl/mdc_pkg.sv
// ---------------------------------------------------------------------------
// mdc_pkg: shared types for the cofactor determinant block
// Sequencer states, control and status bundles, register indexes.
// ---------------------------------------------------------------------------
package mdc_pkg;

  localparam int CFG_W = 3;
  localparam int OUT_W = 64;

  localparam logic [CFG_W-1:0] REG_ROW_COUNT    = 3'd0;
  localparam logic [CFG_W-1:0] REG_COLUMN_COUNT = 3'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_ADD,
    S_DONE
  } mdc_state_t;

  typedef struct packed {
    logic start;
    logic not_square;
    logic ack;
  } mdc_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic not_square;
  } mdc_status_t;

endpackage

### hdl/mdc_core.sv
// ---------------------------------------------------------------------------
// mdc_core: permutation sequencer with a shared limb multiplier
// Holds the matrix, walks every permutation in Lehmer-code order, forms each
// signed product one limb per cycle and accumulates the exact sum.
// ---------------------------------------------------------------------------
module mdc_core #(
  parameter int MAX_SIZE      = 4,
  parameter int ELEMENT_WIDTH = 16,
  parameter int NW            = 3,
  parameter int AB            = 4,
  parameter int AW            = 75
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mdc_pkg::mdc_ctrl_t       ctrl,
  input  logic [NW-1:0]            size,
  input  logic                     wr_en,
  input  logic [AB-1:0]            wr_addr,
  input  logic [ELEMENT_WIDTH-1:0] wr_data,
  output mdc_pkg::mdc_status_t     status,
  output logic [AW-1:0]            acc
);
  import mdc_pkg::*;

  localparam int EW    = ELEMENT_WIDTH;
  localparam int CELLS = MAX_SIZE * MAX_SIZE;
  localparam int RB    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  mdc_state_t state, state_next;

  logic [EW-1:0]   mem [CELLS];
  logic [EW-1:0]   rd_data;
  logic [AB-1:0]   rd_addr;
  logic [NW-1:0]   n;
  logic [RB-1:0]   row;
  logic [RB-1:0]   limb;
  logic [RB-1:0]   dig [MAX_SIZE];
  logic [RB-1:0]   dig_next [MAX_SIZE];
  logic            wrap;
  logic [MAX_SIZE-1:0] used;
  logic [RB-1:0]   col;
  logic [EW-1:0]   mag [MAX_SIZE];
  logic [EW-1:0]   carry;
  logic            psign;
  logic            parity;
  logic            ns;
  logic [EW-1:0]   emag;
  logic [2*EW-1:0] prod;
  logic [AW-1:0]   magv;
  logic [AW-1:0]   term;
  logic            last_row;
  logic            last_limb;

  // Pick the dig[row]-th column not yet used by this permutation.
  always_comb begin
    int cnt;
    cnt = 0;
    col = '0;
    for (int c = 0; c < MAX_SIZE; c++) begin
      if ((c < int'(n)) && !used[c]) begin
        if (cnt == int'(dig[row])) begin
          col = RB'(c);
        end
        cnt = cnt + 1;
      end
    end
  end

  assign rd_addr = AB'(int'(row) * int'(n) + int'(col));

  // Mixed-radix increment of the Lehmer code; digit k has radix n-k.
  always_comb begin
    logic cy;
    cy = 1'b1;
    for (int k = 0; k < MAX_SIZE; k++) begin
      dig_next[k] = dig[k];
      if ((k < int'(n)) && cy) begin
        if (int'(dig[k]) == int'(n) - 1 - k) begin
          dig_next[k] = '0;
        end else begin
          dig_next[k] = dig[k] + RB'(1);
          cy = 1'b0;
        end
      end
    end
    wrap = cy;
  end

  // Permutation parity equals the parity of the sum of Lehmer digits.
  always_comb begin
    parity = 1'b0;
    for (int k = 0; k < MAX_SIZE; k++) begin
      parity = parity ^ dig[k][0];
    end
  end

  assign emag = rd_data[EW-1] ? (~rd_data + EW'(1)) : rd_data;
  assign prod = (2*EW)'(mag[0]) * (2*EW)'(emag) + (2*EW)'(carry);

  always_comb begin
    magv = '0;
    for (int k = 0; k < MAX_SIZE; k++) begin
      magv[k*EW +: EW] = mag[k];
    end
  end

  assign term      = (psign ^ parity) ? (~magv + AW'(1)) : magv;
  assign last_row  = (int'(row) == int'(n) - 1);
  assign last_limb = (int'(limb) == MAX_SIZE - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (ctrl.start) begin
          state_next = ctrl.not_square ? S_DONE : S_FETCH;
        end
      end
      S_FETCH: state_next = S_MUL;
      S_MUL: begin
        if (last_limb) begin
          state_next = last_row ? S_ADD : S_FETCH;
        end
      end
      S_ADD:   state_next = wrap ? S_DONE : S_FETCH;
      S_DONE: begin
        if (ctrl.ack) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state == S_FETCH) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (ctrl.start) begin
          n     <= size;
          ns    <= ctrl.not_square;
          acc   <= '0;
          row   <= '0;
          used  <= '0;
          psign <= 1'b0;
          for (int k = 0; k < MAX_SIZE; k++) begin
            dig[k] <= '0;
            mag[k] <= (k == 0) ? EW'(1) : '0;
          end
        end
      end
      S_FETCH: begin
        used[col] <= 1'b1;
        limb      <= '0;
        carry     <= '0;
      end
      S_MUL: begin
        if (limb == '0) begin
          psign <= psign ^ rd_data[EW-1];
        end
        for (int k = 0; k < MAX_SIZE - 1; k++) begin
          mag[k] <= mag[k+1];
        end
        mag[MAX_SIZE-1] <= prod[EW-1:0];
        carry           <= prod[2*EW-1:EW];
        limb            <= limb + RB'(1);
        if (last_limb && !last_row) begin
          row <= row + RB'(1);
        end
      end
      S_ADD: begin
        acc   <= acc + term;
        row   <= '0;
        used  <= '0;
        psign <= 1'b0;
        for (int k = 0; k < MAX_SIZE; k++) begin
          dig[k] <= dig_next[k];
          mag[k] <= (k == 0) ? EW'(1) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign status.idle       = (state == S_IDLE);
  assign status.done       = (state == S_DONE);
  assign status.not_square = ns;

endmodule

### hdl/matrix_determinant_cofactor.sv
// ---------------------------------------------------------------------------
// matrix_determinant_cofactor: exact determinant of a loaded matrix
// Loads elements row-major, then sums every signed permutation product.
// ---------------------------------------------------------------------------
// Elements arrive in row-major order, one transfer per cycle while in_ready
// is high; the matrix size comes from the row_count and column_count
// registers (zero acts as one, values above MAX_SIZE act as MAX_SIZE), and
// a write to either of those registers drops any partially loaded matrix.
// After the last element the block stops taking input and expands the
// determinant as the sum over all n! permutations, which is the same value
// as cofactor expansion along the first column. One limb multiplier
// (ELEMENT_WIDTH by ELEMENT_WIDTH) is shared: for each permutation the
// block fetches each of its n elements in turn, multiplies it into the
// running product limb by limb, and then adds the signed product to the
// sum. A non-square matrix returns zero with not_square set. The sum is
// exact and is saturated to 64 bits at the output, with overflowed set
// when that happens. The result waits in an output register until its
// transfer, while the next matrix is already loading.
module matrix_determinant_cofactor #(
  parameter int MAX_SIZE      = 4,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mdc_pkg::CFG_W-1:0]        cfg_index,
  input  logic [mdc_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [ELEMENT_WIDTH-1:0]  element_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [mdc_pkg::OUT_W-1:0] determinant_value,
  output logic                             not_square,
  output logic                             overflowed
);
  import mdc_pkg::*;

  localparam int CELLS = MAX_SIZE * MAX_SIZE;
  localparam int AB    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int NW    = $clog2(MAX_SIZE + 1);
  // Product magnitude plus room for up to 720 terms and the sign.
  localparam int PW    = ELEMENT_WIDTH * MAX_SIZE;
  localparam int AW    = (PW + 11 > OUT_W + 1) ? PW + 11 : OUT_W + 1;

  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] column_count;
  logic [CW-1:0]    load_count;
  logic [NW-1:0]    rows_eff;
  logic [NW-1:0]    cols_eff;
  logic [CW-1:0]    total;
  logic             in_xfer;
  logic             last_elem;
  mdc_ctrl_t        ctrl;
  mdc_status_t      status;
  logic [AW-1:0]    acc;
  logic             fits;
  logic             load_out;

  always_comb begin
    rows_eff = (row_count == '0) ? NW'(1) :
               (int'(row_count) > MAX_SIZE) ? NW'(MAX_SIZE) : NW'(row_count);
    cols_eff = (column_count == '0) ? NW'(1) :
               (int'(column_count) > MAX_SIZE) ? NW'(MAX_SIZE) : NW'(column_count);
  end

  assign total     = CW'(int'(rows_eff) * int'(cols_eff));
  assign in_ready  = status.idle;
  assign in_xfer   = in_valid && in_ready;
  assign last_elem = (load_count + CW'(1)) == total;

  assign ctrl.start      = in_xfer && last_elem;
  assign ctrl.not_square = (rows_eff != cols_eff);
  // The finished result moves into the output register once it is free.
  assign load_out        = status.done && (!out_valid || out_ready);
  assign ctrl.ack        = load_out;

  mdc_core #(
    .MAX_SIZE      (MAX_SIZE),
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .NW            (NW),
    .AB            (AB),
    .AW            (AW)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .size    (rows_eff),
    .wr_en   (in_xfer),
    .wr_addr (AB'(load_count)),
    .wr_data (element_value),
    .status  (status),
    .acc     (acc)
  );

  // Configuration and load counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= CFG_W'(1);
      column_count <= CFG_W'(1);
      load_count   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_COUNT: begin
          row_count  <= cfg_data;
          load_count <= '0;
        end
        REG_COLUMN_COUNT: begin
          column_count <= cfg_data;
          load_count   <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_xfer) begin
      load_count <= last_elem ? '0 : load_count + CW'(1);
    end
  end

  // The exact sum fits when every bit above bit 62 matches the sign.
  assign fits = (&acc[AW-1:OUT_W-1]) || !(|acc[AW-1:OUT_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      not_square <= status.not_square;
      if (status.not_square) begin
        determinant_value <= '0;
        overflowed        <= 1'b0;
      end else if (fits) begin
        determinant_value <= acc[OUT_W-1:0];
        overflowed        <= 1'b0;
      end else begin
        determinant_value <= acc[AW-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                       : {1'b0, {(OUT_W-1){1'b1}}};
        overflowed        <= 1'b1;
      end
    end
  end

endmodule
